// ----- rtl/dsbf_pkg.sv -----
package dsbf_pkg;

   // line control characters
   localparam logic [7:0] DLE_CHAR = 8'h10;
   localparam logic [7:0] STX_CHAR = 8'h02;
   localparam logic [7:0] ETX_CHAR = 8'h03;

   // input item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_frame;
   } req_type;

   // result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [7:0] data;
      logic       hdr;
      logic       esc;
      logic       eof;
      logic [7:0] bcc;
   } desc_type;

   // one line byte slot of an item
   typedef enum logic [2:0] {
      ST_HDR_DLE,
      ST_HDR_STX,
      ST_ESC,
      ST_DATA,
      ST_TRL_DLE,
      ST_TRL_ETX,
      ST_TRL_BCC
   } step_type;

   function automatic step_type first_step(input desc_type d);
      step_type s;
      if (d.hdr) begin
         s = ST_HDR_DLE;
      end else if (d.esc) begin
         s = ST_ESC;
      end else begin
         s = ST_DATA;
      end
      return s;
   endfunction

   function automatic step_type next_step(input step_type s, input desc_type d);
      step_type n;
      unique case (s)
         ST_HDR_DLE: n = ST_HDR_STX;
         ST_HDR_STX: n = d.esc ? ST_ESC : ST_DATA;
         ST_ESC:     n = ST_DATA;
         ST_DATA:    n = ST_TRL_DLE;
         ST_TRL_DLE: n = ST_TRL_ETX;
         ST_TRL_ETX: n = ST_TRL_BCC;
         default:    n = ST_DATA;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] step_byte(input step_type s, input desc_type d);
      logic [7:0] b;
      unique case (s)
         ST_HDR_DLE: b = DLE_CHAR;
         ST_HDR_STX: b = STX_CHAR;
         ST_ESC:     b = DLE_CHAR;
         ST_DATA:    b = d.data;
         ST_TRL_DLE: b = DLE_CHAR;
         ST_TRL_ETX: b = ETX_CHAR;
         ST_TRL_BCC: b = d.bcc;
         default:    b = d.data;
      endcase
      return b;
   endfunction

   function automatic logic step_last(input step_type s, input desc_type d);
      return (s == ST_TRL_BCC) || ((s == ST_DATA) && !d.eof);
   endfunction

endpackage

// ----- rtl/dsbf_front.sv -----
module dsbf_front
   import dsbf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   input  logic     q_full,
   output logic     q_push,
   output desc_type q_desc
);

   logic       inside_frame_ff, inside_frame_in;
   logic [7:0] check_accum_ff, check_accum_in;
   logic [7:0] sum;

   // classify the item and update the frame state
   always_comb begin
      req_ready = !q_full;
      q_push    = req_valid && !q_full;
      sum       = (inside_frame_ff ? check_accum_ff : 8'h00) ^ req_data.data_byte;

      q_desc.data = req_data.data_byte;
      q_desc.hdr  = !inside_frame_ff;
      q_desc.esc  = (req_data.data_byte == DLE_CHAR);
      q_desc.eof  = req_data.end_of_frame;
      q_desc.bcc  = sum ^ ETX_CHAR;

      inside_frame_in = inside_frame_ff;
      check_accum_in  = check_accum_ff;
      if (q_push) begin
         inside_frame_in = !req_data.end_of_frame;
         check_accum_in  = req_data.end_of_frame ? 8'h00 : sum;
      end
   end

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         inside_frame_ff <= 1'b0;
         check_accum_ff  <= 8'h00;
      end else begin
         inside_frame_ff <= inside_frame_in;
         check_accum_ff  <= check_accum_in;
      end
   end

   // end of frame closes the frame and clears the check
   a_eof_closes: assert property (@(posedge clock) disable iff (reset)
      (q_push && req_data.end_of_frame) |=> (!inside_frame_ff && check_accum_ff == 8'h00))
      else $error("frame state not cleared after end of frame");

   // a body item keeps the frame open
   a_body_opens: assert property (@(posedge clock) disable iff (reset)
      (q_push && !req_data.end_of_frame) |=> inside_frame_ff)
      else $error("frame not open after body item");

endmodule

// ----- rtl/dsbf_queue.sv -----
module dsbf_queue
   import dsbf_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output desc_type head,
   output logic     empty,
   output logic     full
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   desc_type             entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff,  count_in;

   // pointer and count update
   always_comb begin
      empty     = (count_ff == CNT_W'(0));
      full      = (count_ff == CNT_W'(DEPTH));
      head      = entry_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue pop while empty");

endmodule

// ----- rtl/dsbf_back.sv -----
module dsbf_back
   import dsbf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  desc_type head,
   input  logic     q_empty,
   output logic     q_pop,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   logic     active_ff, active_in;
   step_type step_ff, step_in;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff, rsp_data_in;
   step_type cur;
   logic     last;
   logic     load;

   // pick the next line byte of the head item
   always_comb begin
      cur          = active_ff ? step_ff : first_step(head);
      last         = step_last(cur, head);
      load         = !q_empty && (!rsp_valid_ff || rsp_ready);
      q_pop        = load && last;
      active_in    = active_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.out_byte = step_byte(cur, head);
         rsp_data_in.out_last = last;
         active_in            = !last;
         step_in              = next_step(cur, head);
      end
   end

   // sequencer control
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         step_ff      <= ST_DATA;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output byte register
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // mid-item the head must still be queued
   a_active_head: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> !q_empty)
      else $error("sequencer active with empty queue");

   // escape byte is always followed by the payload byte
   a_esc_then_data: assert property (@(posedge clock) disable iff (reset)
      (load && cur == ST_ESC) |=> (active_ff && step_ff == ST_DATA))
      else $error("escape not followed by data");

endmodule

// ----- rtl/dle_stuffing_bcc_framer.sv -----
// DLE/STX/ETX byte-stuffing framer with XOR block check. Each input item is one
// payload byte plus an end-of-frame flag; the block sends DLE STX before the first
// byte of a frame, doubles payload DLE bytes, and after the last byte sends DLE ETX
// and the check byte (XOR of the payload bytes, XOR ETX). out_last marks the final
// line byte caused by each item. Items are taken one per cycle while the queue
// (QUEUE_DEPTH entries, at least 2) has room; the output side sends one line byte
// per cycle from a single output register unless rsp_ready or an empty queue stalls
// it, so an item costs 1 line byte for a plain body byte, 2 for an escaped DLE, and
// up to 7 for a one-byte frame with an escaped DLE. The output limits the rate.
module dle_stuffing_bcc_framer
   import dsbf_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   desc_type push_desc;
   desc_type head;
   logic     push;
   logic     pop;
   logic     q_empty;
   logic     q_full;

   // accept and classify
   dsbf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (push),
      .q_desc    (push_desc)
   );

   // decoupling queue
   dsbf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   // line byte sequencer
   dsbf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_empty   (q_empty),
      .q_pop     (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
